// File: design/rtts_pkg.sv
// Shared widths and interface types for the round-trip time statistics block.
package rtts_pkg;

  localparam int CNT_W = 16;
  localparam int RTT_W = 24;
  localparam int SUM_W = 40;
  localparam int SQ_W  = 64;
  localparam int DIG_W = 8;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sumsq;
  } rtts_acc_t;

  typedef struct packed {
    logic start;
    logic ack;
  } rtts_ctl_t;

  typedef struct packed {
    logic             done;
    logic [RTT_W-1:0] mean;
    logic [RTT_W-1:0] stddev;
  } rtts_res_t;

endpackage

// File: design/rtts_report.sv
// Bit-serial report engine: floor mean and floor population deviation.
module rtts_report (
  input  logic                clk,
  input  logic                rst_n,
  input  rtts_pkg::rtts_ctl_t ctl,
  input  rtts_pkg::rtts_acc_t acc,
  output rtts_pkg::rtts_res_t res
);
  import rtts_pkg::*;

  localparam int P_W   = CNT_W + SQ_W;
  localparam int DVS_W = 2 * CNT_W;
  localparam int RT_W  = SQ_W / 2;
  localparam int IT_W  = $clog2(P_W + 1);

  typedef enum logic [3:0] {
    R_IDLE, R_DIV_M, R_MUL_P, R_MUL_S, R_SUB, R_MUL_N, R_DIV_V, R_SQRT, R_DONE
  } rstate_t;

  rstate_t          state_r;
  logic [IT_W-1:0]  it_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]  sq_r;
  logic [SQ_W-1:0]  mul_a_r;
  logic [SUM_W-1:0] mbits_r;
  logic [P_W-1:0]   acc_r;
  logic [P_W-1:0]   p_r;
  logic [P_W-1:0]   dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic             neg_r;
  logic [RT_W-1:0]  rt_r;
  logic [RT_W:0]    srem_r;
  logic [RTT_W-1:0] mean_r;
  logic [RTT_W-1:0] sd_r;

  logic [P_W-1:0]   mul_add;
  logic [P_W-1:0]   acc_step;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_df;
  logic             div_ge;
  logic [DVS_W-1:0] rem_step;
  logic [P_W-1:0]   dvd_div;
  logic [RT_W+2:0]  sq_t;
  logic [RT_W+2:0]  sq_c;
  logic [RT_W+2:0]  sq_df;
  logic             sq_ge;
  logic [RT_W:0]    srem_step;
  logic [RT_W-1:0]  rt_step;
  logic [P_W:0]     d_full;
  logic [SUM_W-1:0] cnt_top;

  // shift-add multiplier, MSB of multiplier first
  assign mul_add  = mbits_r[SUM_W-1] ? P_W'(mul_a_r) : '0;
  assign acc_step = {acc_r[P_W-2:0], 1'b0} + mul_add;

  // restoring divider, quotient shifts in behind the dividend
  assign rem_sh   = {rem_r, dvd_r[P_W-1]};
  assign rem_df   = rem_sh - {1'b0, dvs_r};
  assign div_ge   = rem_sh >= {1'b0, dvs_r};
  assign rem_step = div_ge ? rem_df[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  assign dvd_div  = {dvd_r[P_W-2:0], div_ge};

  // digit-by-digit root, two radicand bits per step
  assign sq_t      = {srem_r, dvd_r[SQ_W-1:SQ_W-2]};
  assign sq_c      = {1'b0, rt_r, 2'b01};
  assign sq_df     = sq_t - sq_c;
  assign sq_ge     = sq_t >= sq_c;
  assign srem_step = sq_ge ? sq_df[RT_W:0] : sq_t[RT_W:0];
  assign rt_step   = {rt_r[RT_W-2:0], sq_ge};

  assign d_full  = {1'b0, p_r} - {1'b0, acc_r};
  assign cnt_top = {cnt_r, {(SUM_W-CNT_W){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      it_r    <= '0;
    end else begin
      unique case (state_r)
        R_IDLE: begin
          if (ctl.start) begin
            cnt_r   <= acc.cnt;
            sum_r   <= acc.sum;
            sq_r    <= acc.sumsq;
            dvd_r   <= P_W'(acc.sum);
            dvs_r   <= DVS_W'(acc.cnt);
            rem_r   <= '0;
            it_r    <= '0;
            state_r <= R_DIV_M;
          end
        end
        R_DIV_M: begin
          dvd_r <= dvd_div;
          rem_r <= rem_step;
          if (it_r == IT_W'(P_W-1)) begin
            mean_r  <= (cnt_r == '0) ? '0 : dvd_div[RTT_W-1:0];
            acc_r   <= '0;
            mul_a_r <= sq_r;
            mbits_r <= cnt_top;
            it_r    <= '0;
            state_r <= R_MUL_P;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        R_MUL_P: begin
          if (it_r == IT_W'(CNT_W-1)) begin
            p_r     <= acc_step;
            acc_r   <= '0;
            mul_a_r <= SQ_W'(sum_r);
            mbits_r <= sum_r;
            it_r    <= '0;
            state_r <= R_MUL_S;
          end else begin
            acc_r   <= acc_step;
            mbits_r <= mbits_r << 1;
            it_r    <= it_r + 1'b1;
          end
        end
        R_MUL_S: begin
          acc_r   <= acc_step;
          mbits_r <= mbits_r << 1;
          it_r    <= it_r + 1'b1;
          if (it_r == IT_W'(SUM_W-1)) begin
            state_r <= R_SUB;
          end
        end
        R_SUB: begin
          neg_r   <= d_full[P_W];
          dvd_r   <= d_full[P_W-1:0];
          acc_r   <= '0;
          mul_a_r <= SQ_W'(cnt_r);
          mbits_r <= cnt_top;
          it_r    <= '0;
          state_r <= R_MUL_N;
        end
        R_MUL_N: begin
          acc_r   <= acc_step;
          mbits_r <= mbits_r << 1;
          if (it_r == IT_W'(CNT_W-1)) begin
            dvs_r   <= acc_step[DVS_W-1:0];
            rem_r   <= '0;
            it_r    <= '0;
            state_r <= R_DIV_V;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        R_DIV_V: begin
          dvd_r <= dvd_div;
          rem_r <= rem_step;
          if (it_r == IT_W'(P_W-1)) begin
            srem_r  <= '0;
            rt_r    <= '0;
            it_r    <= '0;
            state_r <= R_SQRT;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        R_SQRT: begin
          srem_r <= srem_step;
          rt_r   <= rt_step;
          dvd_r  <= {dvd_r[P_W-3:0], 2'b00};
          if (it_r == IT_W'(RT_W-1)) begin
            sd_r    <= (cnt_r < CNT_W'(2) || neg_r) ? '0 : rt_step[RTT_W-1:0];
            it_r    <= '0;
            state_r <= R_DONE;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        R_DONE: begin
          if (ctl.ack) begin
            state_r <= R_IDLE;
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  assign res.done   = (state_r == R_DONE);
  assign res.mean   = mean_r;
  assign res.stddev = sd_r;

endmodule

// File: design/round_trip_time_statistics_top.sv
// Top level of the round-trip time statistics accumulator.
// For an add request, count, min, max and sum update at acceptance, and the square is
// accumulated by an 8-bit digit-serial multiplier, one digit per cycle, with in_ready low.
// Samples past MAX_SAMPLES only set the dropped flag. A report request runs in a
// bit-serial engine (one 80-step divide for the mean, shift-add products n*sumsq, sum^2
// and n^2, a second 80-step divide and a 32-step square root) and returns one result;
// the accumulators clear once it is loaded into the output register, which can hold a
// result while new adds are taken.
module round_trip_time_statistics_top #(
  parameter int MAX_SAMPLES = 65535,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [rtts_pkg::RTT_W-1:0] in_rtt_us,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rtts_pkg::CNT_W-1:0] out_sample_count,
  output logic [rtts_pkg::RTT_W-1:0] out_min_us,
  output logic [rtts_pkg::RTT_W-1:0] out_max_us,
  output logic [rtts_pkg::RTT_W-1:0] out_mean_us,
  output logic [rtts_pkg::RTT_W-1:0] out_stddev_us,
  output logic                       out_has_samples,
  output logic                       out_samples_dropped
);
  import rtts_pkg::*;

  localparam int NDIG   = (SAMPLE_BITS + DIG_W - 1) / DIG_W;
  localparam int MC_W   = SAMPLE_BITS + DIG_W * (NDIG - 1);
  localparam int MD_W   = DIG_W * NDIG;
  localparam int DCNT_W = $clog2(NDIG + 1);

  typedef enum logic [1:0] {S_IDLE, S_SQ, S_REP} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [RTT_W-1:0]  min_r;
  logic [RTT_W-1:0]  max_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   sumsq_r;
  logic              ovf_r;
  logic [MC_W-1:0]   mcand_r;
  logic [MD_W-1:0]   mdig_r;
  logic [DCNT_W-1:0] dig_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic [RTT_W-1:0]  out_min_r;
  logic [RTT_W-1:0]  out_max_r;
  logic [RTT_W-1:0]  out_mean_r;
  logic [RTT_W-1:0]  out_sd_r;
  logic              out_has_r;
  logic              out_drop_r;

  logic                  acc_in;
  logic [RTT_W-1:0]      rtt_s;
  logic                  full;
  logic                  rep_load;
  logic [MC_W+DIG_W-1:0] sq_prod;
  rtts_ctl_t             ctl;
  rtts_acc_t             acc;
  rtts_res_t             res;

  assign in_ready = (state_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign rtt_s    = RTT_W'(in_rtt_us[SAMPLE_BITS-1:0]);
  assign full     = (count_r >= CNT_W'(MAX_SAMPLES));
  assign rep_load = (state_r == S_REP) && res.done && (!out_valid_r || out_ready);
  assign sq_prod  = mcand_r * mdig_r[DIG_W-1:0];

  assign ctl.start = acc_in && in_action;
  assign ctl.ack   = rep_load;
  assign acc.cnt   = count_r;
  assign acc.sum   = sum_r;
  assign acc.sumsq = sumsq_r;

  rtts_report u_report (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .acc   (acc),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      ovf_r       <= 1'b0;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !rep_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            if (in_action) begin
              state_r <= S_REP;
            end else if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + 1'b1;
              if (rtt_s < min_r) min_r <= rtt_s;
              if (rtt_s > max_r) max_r <= rtt_s;
              sum_r   <= sum_r + SUM_W'(rtt_s);
              mcand_r <= MC_W'(in_rtt_us[SAMPLE_BITS-1:0]);
              mdig_r  <= MD_W'(in_rtt_us[SAMPLE_BITS-1:0]);
              dig_r   <= '0;
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          sumsq_r <= sumsq_r + SQ_W'(sq_prod);
          mcand_r <= mcand_r << DIG_W;
          mdig_r  <= mdig_r >> DIG_W;
          dig_r   <= dig_r + 1'b1;
          if (dig_r == DCNT_W'(NDIG - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_REP: begin
          if (rep_load) begin
            out_valid_r <= 1'b1;
            out_cnt_r   <= count_r;
            out_min_r   <= (count_r == '0) ? '0 : min_r;
            out_max_r   <= (count_r == '0) ? '0 : max_r;
            out_mean_r  <= res.mean;
            out_sd_r    <= res.stddev;
            out_has_r   <= (count_r != '0);
            out_drop_r  <= ovf_r;
            count_r     <= '0;
            min_r       <= '1;
            max_r       <= '0;
            sum_r       <= '0;
            sumsq_r     <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_count    = out_cnt_r;
  assign out_min_us          = out_min_r;
  assign out_max_us          = out_max_r;
  assign out_mean_us         = out_mean_r;
  assign out_stddev_us       = out_sd_r;
  assign out_has_samples     = out_has_r;
  assign out_samples_dropped = out_drop_r;

endmodule

// File: tb/tb_round_trip_time_statistics_top.sv
// Self-checking testbench for the round-trip time statistics accumulator.
`timescale 1ns / 1ps

module tb_round_trip_time_statistics_top;
  import rtts_pkg::*;

  localparam int MAX_SAMPLES = 65535;
  localparam int SAMPLE_BITS = 24;
  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 300;
  localparam int RANDOM_ITEMS = 400;
  localparam int MIN_REPORTS = 50;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  localparam logic [RTT_W-1:0] SAMPLE_MASK = {RTT_W{1'b1}} >> (RTT_W - SAMPLE_BITS);
  localparam logic [RTT_W-1:0] RTT_ALL_ONES = {RTT_W{1'b1}};

  typedef struct {
    logic [CNT_W-1:0] sample_count;
    logic [RTT_W-1:0] min_us;
    logic [RTT_W-1:0] max_us;
    logic [RTT_W-1:0] mean_us;
    logic [RTT_W-1:0] stddev_us;
    logic             has_samples;
    logic             samples_dropped;
  } rtt_report_t;

  class rtt_stats_scoreboard;
    logic [CNT_W-1:0] n;
    logic [RTT_W-1:0] lo_us;
    logic [RTT_W-1:0] hi_us;
    logic [SUM_W-1:0] total;
    logic [SQ_W-1:0]  total_sq;
    logic             dropped;
    rtt_report_t      pending[$];
    int               errors;
    int               adds;
    int               reports;
    int               checked;
    int               drops;

    function new();
      errors  = 0;
      adds    = 0;
      reports = 0;
      checked = 0;
      drops   = 0;
      clear();
    endfunction

    function void clear();
      n        = '0;
      lo_us    = RTT_ALL_ONES;
      hi_us    = '0;
      total    = '0;
      total_sq = '0;
      dropped  = 1'b0;
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function logic [RTT_W-1:0] spread();
      logic [127:0] scaled_sq;
      logic [127:0] sum_sq;
      logic [127:0] quot;
      if (n < 2) return '0;
      scaled_sq = 128'(n) * 128'(total_sq);
      sum_sq    = 128'(total) * 128'(total);
      if (scaled_sq < sum_sq) return '0;
      quot = (scaled_sq - sum_sq) / (128'(n) * 128'(n));
      return RTT_W'(floor_sqrt(quot[63:0]));
    endfunction

    function void note_request(logic act, logic [RTT_W-1:0] rtt);
      logic [RTT_W-1:0] s;
      rtt_report_t      r;
      s = rtt & SAMPLE_MASK;
      if (act == ACT_ADD) begin
        adds++;
        if (n >= MAX_SAMPLES) begin
          dropped = 1'b1;
          drops++;
        end else begin
          n++;
          if (s < lo_us) lo_us = s;
          if (s > hi_us) hi_us = s;
          total    = total + SUM_W'(s);
          total_sq = total_sq + SQ_W'(s) * SQ_W'(s);
        end
      end else begin
        reports++;
        if (n == 0) begin
          r.sample_count = '0;
          r.min_us       = '0;
          r.max_us       = '0;
          r.mean_us      = '0;
          r.stddev_us    = '0;
          r.has_samples  = 1'b0;
        end else begin
          r.sample_count = n;
          r.min_us       = lo_us;
          r.max_us       = hi_us;
          r.mean_us      = RTT_W'(total / SUM_W'(n));
          r.stddev_us    = spread();
          r.has_samples  = 1'b1;
        end
        r.samples_dropped = dropped;
        pending.push_back(r);
        clear();
      end
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(rtt_report_t got);
      rtt_report_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no report request outstanding");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      compare_field("sample_count", 64'(exp_r.sample_count), 64'(got.sample_count));
      compare_field("min_us", 64'(exp_r.min_us), 64'(got.min_us));
      compare_field("max_us", 64'(exp_r.max_us), 64'(got.max_us));
      compare_field("mean_us", 64'(exp_r.mean_us), 64'(got.mean_us));
      compare_field("stddev_us", 64'(exp_r.stddev_us), 64'(got.stddev_us));
      compare_field("has_samples", 64'(exp_r.has_samples), 64'(got.has_samples));
      compare_field("samples_dropped", 64'(exp_r.samples_dropped),
                    64'(got.samples_dropped));
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_action;
  logic [RTT_W-1:0] in_rtt_us;
  logic             out_valid;
  logic             out_ready;
  logic [CNT_W-1:0] out_sample_count;
  logic [RTT_W-1:0] out_min_us;
  logic [RTT_W-1:0] out_max_us;
  logic [RTT_W-1:0] out_mean_us;
  logic [RTT_W-1:0] out_stddev_us;
  logic             out_has_samples;
  logic             out_samples_dropped;

  logic quiet;
  int   hold_ask;
  int   hold_served;

  rtt_stats_scoreboard sb;

  round_trip_time_statistics_top #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_rtt_us          (in_rtt_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_count   (out_sample_count),
    .out_min_us         (out_min_us),
    .out_max_us         (out_max_us),
    .out_mean_us        (out_mean_us),
    .out_stddev_us      (out_stddev_us),
    .out_has_samples    (out_has_samples),
    .out_samples_dropped(out_samples_dropped)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin : monitor
    rtt_report_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_action, in_rtt_us);
      if (out_valid && out_ready) begin
        got.sample_count    = out_sample_count;
        got.min_us          = out_min_us;
        got.max_us          = out_max_us;
        got.mean_us         = out_mean_us;
        got.stddev_us       = out_stddev_us;
        got.has_samples     = out_has_samples;
        got.samples_dropped = out_samples_dropped;
        sb.check_result(got);
      end
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    out_ready   = 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 24);
      end
    end
  end

  function automatic logic [RTT_W-1:0] pick_rtt(int mode);
    case (mode)
      0: return RTT_W'($urandom);
      1: return RTT_W'($urandom_range(0, 255));
      2: return RTT_ALL_ONES - RTT_W'($urandom_range(0, 255));
      default: return $urandom_range(1) ? RTT_ALL_ONES : '0;
    endcase
  endfunction

  task automatic send_request(input logic act, input logic [RTT_W-1:0] rtt);
    in_valid  <= 1'b1;
    in_action <= act;
    in_rtt_us <= rtt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_count() != 0);
    @(posedge clk);
  endtask

  initial begin
    int burst;
    int len;
    int mode;
    int random_sent;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = ACT_ADD;
    in_rtt_us = '0;
    quiet     = 1'b0;
    hold_ask  = 0;
    sb        = new();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty report, single samples, extremes, flat set, clear check
    send_request(ACT_REPORT, RTT_W'($urandom));
    send_request(ACT_ADD, '0);
    send_request(ACT_REPORT, '0);
    send_request(ACT_ADD, RTT_ALL_ONES);
    send_request(ACT_REPORT, RTT_ALL_ONES);
    send_request(ACT_ADD, '0);
    send_request(ACT_ADD, RTT_ALL_ONES);
    send_request(ACT_REPORT, '0);
    repeat (3) send_request(ACT_ADD, 24'd5);
    send_request(ACT_REPORT, RTT_W'($urandom));
    send_request(ACT_ADD, 24'd1000);
    send_request(ACT_ADD, 24'd1);
    send_request(ACT_ADD, 24'h800000);
    send_request(ACT_ADD, 24'h7FFFFF);
    send_request(ACT_ADD, 24'd37);
    send_request(ACT_REPORT, RTT_ALL_ONES);
    send_request(ACT_REPORT, '0);
    drain_results();

    // random bursts of adds closed by a report, with some noise
    burst       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS || sb.reports < MIN_REPORTS) begin
      if (burst == 6 || burst == 45) hold_ask <= hold_ask + 1;
      if (burst == 20) quiet <= 1'b1;
      if (burst == 32) quiet <= 1'b0;
      if (burst == 40) drain_results();
      if ($urandom_range(7) == 0) begin
        len = $urandom_range(1, 6);
        repeat (len) send_request(1'($urandom_range(1)), RTT_W'($urandom));
        random_sent += len;
      end else begin
        len  = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        mode = $urandom_range(3);
        repeat (len) send_request(ACT_ADD, pick_rtt(mode));
        send_request(ACT_REPORT, RTT_W'($urandom));
        random_sent += len + 1;
      end
      burst++;
    end
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d add and %0d report requests, %0d dropped samples.",
             sb.adds, sb.reports, sb.drops);
    $display("Checked %0d results, including empty reports and long output stalls.",
             sb.checked);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
